[rtl/sensorless_flux_observer_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the flux observer checkers
// ----------------------------------------------------------------------------
`ifndef SENSORLESS_FLUX_OBSERVER_TOP_MACROS_SVH
`define SENSORLESS_FLUX_OBSERVER_TOP_MACROS_SVH

// Clocked check, off while reset is asserted
`define SFO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define SFO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/sfo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfo_pkg
// Types, constants, microcode and helpers of the sensorless flux observer.
// ----------------------------------------------------------------------------
package sfo_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int SAT_W        = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    localparam int OP_W     = 33;
    localparam int PROD_W   = 2 * OP_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SUM_W    = ACC_W + 1;
    localparam int CORDIC_W = 36;
    localparam int Z_W      = 34;
    localparam int STEP_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int UOP_N    = 18;
    localparam int UOP_W    = 5;

    localparam logic [31:0] CORDIC_K = 32'd652032874;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((65'sd1 <<< (SAT_W - 1)) - 65'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    typedef struct packed {
        logic signed [31:0] volt_alpha;
        logic signed [31:0] volt_beta;
        logic signed [31:0] curr_alpha;
        logic signed [31:0] curr_beta;
    } t_in_word;

    typedef struct packed {
        logic        [15:0] rotor_angle;
        logic signed [31:0] flux_alpha_est;
        logic signed [31:0] flux_beta_est;
    } t_out_word;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_RESISTANCE = 3'd1,
        REG_INDUCTANCE = 3'd2,
        REG_INV_IND    = 3'd3,
        REG_MAGNET     = 3'd4,
        REG_GAIN_A     = 3'd5,
        REG_GAIN_B     = 3'd6,
        REG_TIME_STEP  = 3'd7
    } t_reg_idx;

    typedef enum logic [4:0] {
        SRC_RS, SRC_LS, SRC_IL, SRC_GA, SRC_GB, SRC_TS, SRC_COS, SRC_SIN,
        SRC_FA, SRC_FB, SRC_IA, SRC_IB, SRC_PCA, SRC_PCB, SRC_D, SRC_Q,
        SRC_DMPM, SRC_EA, SRC_EB, SRC_TA, SRC_TB
    } t_src;

    typedef enum logic [3:0] {
        K_VA, K_VB, K_IA, K_IB, K_FA, K_FB, K_PM, K_XA, K_XB
    } t_ksel;

    typedef enum logic [3:0] {
        DST_XA, DST_XB, DST_LA, DST_LB, DST_D, DST_Q, DST_EA, DST_EB,
        DST_TA, DST_TB, DST_FA, DST_FB
    } t_dst;

    // SAT: sat(r); KSUB: sat(k - sat(r)); SUBK: sat(sat(r) - k); ADDK: sat(k + r)
    typedef enum logic [1:0] {POST_SAT, POST_KSUB, POST_SUBK, POST_ADDK} t_post;
    typedef enum logic [1:0] {SH_16, SH_20, SH_28, SH_30} t_shift;

    typedef struct packed {
        t_src   a;
        t_src   b;
        logic   neg;
        logic   first;
        logic   last;
        t_shift sh;
        t_post  post;
        t_ksel  k;
        t_dst   dst;
    } t_uop;

    typedef struct packed {
        logic   mul_en;
        logic   acc_en;
        logic   first;
        logic   neg;
        t_shift sh;
        t_post  post;
    } t_mac_ctrl;

    typedef struct packed {
        logic load;
        logic run;
        logic vector;
    } t_cor_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SINCOS, ST_SCSTORE, ST_MUL, ST_ACC, ST_WB, ST_DIFF,
        ST_ALOAD, ST_ATAN, ST_DONE
    } t_state;

    function automatic logic signed [31:0] sat(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] c;
        begin
            if (x > SAT_HI) begin
                c = SAT_HI;
            end else if (x < SAT_LO) begin
                c = SAT_LO;
            end else begin
                c = x;
            end
            return c[31:0];
        end
    endfunction

    // atan(2^-i) as a fraction of a turn, 32 bits
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    // Microcode: one product term per entry; mode selects the error model
    function automatic t_uop uop_rom(input logic [UOP_W-1:0] idx, input logic mode);
        t_uop u;
        begin
            u = '{SRC_RS, SRC_PCA, 1'b0, 1'b1, 1'b1, SH_16, POST_SAT, K_VA, DST_XA};
            unique case (idx)
                5'd0:  u = '{SRC_RS, SRC_PCA, 1'b0, 1'b1, 1'b1, SH_16, POST_KSUB, K_VA, DST_XA};
                5'd1:  u = '{SRC_RS, SRC_PCB, 1'b0, 1'b1, 1'b1, SH_16, POST_KSUB, K_VB, DST_XB};
                5'd2:  u = '{SRC_LS, SRC_IA, 1'b0, 1'b1, 1'b1, SH_16, POST_SAT, K_VA, DST_LA};
                5'd3:  u = '{SRC_LS, SRC_IB, 1'b0, 1'b1, 1'b1, SH_16, POST_SAT, K_VA, DST_LB};
                5'd4:  u = '{SRC_COS, mode ? SRC_IA : SRC_FA, 1'b0, 1'b1, 1'b0,
                             SH_30, POST_SAT, K_VA, DST_D};
                5'd5:  u = '{SRC_SIN, mode ? SRC_IB : SRC_FB, 1'b0, 1'b0, 1'b1,
                             SH_30, POST_SAT, K_VA, DST_D};
                5'd6:  u = '{SRC_COS, mode ? SRC_IB : SRC_FB, 1'b0, 1'b1, 1'b0,
                             SH_30, POST_SAT, K_VA, DST_Q};
                5'd7:  u = '{SRC_SIN, mode ? SRC_IA : SRC_FA, 1'b1, 1'b0, 1'b1,
                             SH_30, POST_SAT, K_VA, DST_Q};
                5'd8:  u = mode ? '{SRC_D, SRC_LS, 1'b0, 1'b1, 1'b1, SH_16, POST_ADDK, K_PM, DST_D}
                                : '{SRC_DMPM, SRC_IL, 1'b0, 1'b1, 1'b1, SH_28, POST_SAT, K_VA,
                                    DST_D};
                5'd9:  u = mode ? '{SRC_Q, SRC_LS, 1'b0, 1'b1, 1'b1, SH_16, POST_SAT, K_VA, DST_Q}
                                : '{SRC_Q, SRC_IL, 1'b0, 1'b1, 1'b1, SH_28, POST_SAT, K_VA, DST_Q};
                5'd10: u = '{SRC_COS, SRC_D, 1'b0, 1'b1, 1'b0, SH_30, POST_SAT, K_VA, DST_EA};
                5'd11: u = mode ? '{SRC_SIN, SRC_Q, 1'b1, 1'b0, 1'b1, SH_30, POST_SUBK, K_FA, DST_EA}
                                : '{SRC_SIN, SRC_Q, 1'b1, 1'b0, 1'b1, SH_30, POST_KSUB, K_IA,
                                    DST_EA};
                5'd12: u = '{SRC_SIN, SRC_D, 1'b0, 1'b1, 1'b0, SH_30, POST_SAT, K_VA, DST_EB};
                5'd13: u = mode ? '{SRC_COS, SRC_Q, 1'b0, 1'b0, 1'b1, SH_30, POST_SUBK, K_FB, DST_EB}
                                : '{SRC_COS, SRC_Q, 1'b0, 1'b0, 1'b1, SH_30, POST_KSUB, K_IB,
                                    DST_EB};
                5'd14: u = '{SRC_EA, SRC_GA, 1'b0, 1'b1, 1'b1, mode ? SH_28 : SH_16,
                             POST_ADDK, K_XA, DST_TA};
                5'd15: u = '{SRC_EB, SRC_GB, 1'b0, 1'b1, 1'b1, mode ? SH_28 : SH_16,
                             POST_ADDK, K_XB, DST_TB};
                5'd16: u = '{SRC_TS, SRC_TA, 1'b0, 1'b1, 1'b1, SH_20, POST_ADDK, K_FA, DST_FA};
                5'd17: u = '{SRC_TS, SRC_TB, 1'b0, 1'b1, 1'b1, SH_20, POST_ADDK, K_FB, DST_FB};
                default: u = '{SRC_RS, SRC_PCA, 1'b0, 1'b1, 1'b1, SH_16, POST_SAT, K_VA, DST_XA};
            endcase
            return u;
        end
    endfunction

endpackage

[rtl/sfo_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfo_if
// Valid/ready channels of the flux observer: sample in, result out, config.
// ----------------------------------------------------------------------------
interface sfo_in_if;
    logic             valid;
    logic             ready;
    sfo_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfo_out_if;
    logic              valid;
    logic              ready;
    sfo_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfo_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/sensorless_flux_observer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensorless_flux_observer_top
// Rotor angle observer: flux integration, model correction, CORDIC atan2.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes one word of alpha-beta voltages and currents (Q16.16).
//   o_out gives one word per input: rotor angle (fraction of a turn) and
//   the rotor flux estimates (Q4.28).
//   i_cfg writes the eight registers by index; it is always ready. The user
//   must write it only while the block is idle; the block does not enforce it.
// Processing:
//   16 CORDIC rotations for sin/cos of the last angle, 18 product terms
//   (multiply, then accumulate) on the one shared multiplier, 14
//   write-backs, 16 CORDIC vectoring steps for the angle, then setup and
//   hand-off. i_in.ready is high only in idle, so a word enters only once
//   the last result has been handed to the output register.
// Reset clears the flux states, previous currents, angle and registers
// (gains and time step to their defaults) and drops o_out.valid.
// When the receiver stalls the result is held in the output register; the
// next word may still enter and is held at its end until the slot frees.
// ----------------------------------------------------------------------------
module sensorless_flux_observer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfo_in_if.sink      i_in,
    sfo_out_if.source   o_out,
    sfo_cfg_if.sink     i_cfg
);

    localparam int AB = sfo_pkg::ANGLE_BITS;

    // configuration
    logic        r_mode;
    logic [30:0] r_rs, r_ls, r_il, r_pm, r_ga, r_gb;
    logic [31:0] r_ts;

    // observer state
    logic signed [31:0] r_fa, r_fb, r_pca, r_pcb;
    logic [AB-1:0]      r_ang;

    // working registers
    logic signed [31:0] r_va, r_vb, r_ia, r_ib;
    logic signed [31:0] r_xa, r_xb, r_la, r_lb, r_d, r_q, r_ea, r_eb, r_ta, r_tb;
    logic signed [31:0] r_oa, r_ob;
    logic signed [sfo_pkg::OP_W-1:0] r_cos, r_sin;
    logic               r_neg, r_zero;
    logic [sfo_pkg::UOP_W-1:0] r_upc, n_upc;

    sfo_pkg::t_state r_state, n_state;

    logic               r_out_valid;
    sfo_pkg::t_out_word r_out;

    sfo_pkg::t_uop      w_uop;
    sfo_pkg::t_mac_ctrl w_mac;
    sfo_pkg::t_cor_ctrl w_cor;
    logic signed [sfo_pkg::OP_W-1:0]     w_a, w_b;
    logic signed [31:0]                  w_k, w_res, w_dmpm;
    logic signed [sfo_pkg::CORDIC_W-1:0] w_cx, w_cy, w_lx, w_ly;
    logic signed [sfo_pkg::Z_W-1:0]      w_cz, w_lz;
    logic                                w_clast;
    logic [31:0]                         w_turn, w_ang32;
    logic [AB-1:0]                       w_ang;
    logic                                w_accept, w_emit;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == sfo_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_rs   <= '0;
            r_ls   <= '0;
            r_il   <= '0;
            r_pm   <= '0;
            r_ga   <= 31'd85197;
            r_gb   <= 31'd85197;
            r_ts   <= 32'd214748;
        end else if (i_cfg.valid) begin
            unique case (sfo_pkg::t_reg_idx'(i_cfg.index))
                sfo_pkg::REG_MODE:       r_mode <= i_cfg.data[0];
                sfo_pkg::REG_RESISTANCE: r_rs   <= i_cfg.data[30:0];
                sfo_pkg::REG_INDUCTANCE: r_ls   <= i_cfg.data[30:0];
                sfo_pkg::REG_INV_IND:    r_il   <= i_cfg.data[30:0];
                sfo_pkg::REG_MAGNET:     r_pm   <= i_cfg.data[30:0];
                sfo_pkg::REG_GAIN_A:     r_ga   <= i_cfg.data[30:0];
                sfo_pkg::REG_GAIN_B:     r_gb   <= i_cfg.data[30:0];
                sfo_pkg::REG_TIME_STEP:  r_ts   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---- operand selection
    assign w_uop  = sfo_pkg::uop_rom(r_upc, r_mode);
    assign w_dmpm = sfo_pkg::sat(sfo_pkg::SUM_W'(r_d) - sfo_pkg::SUM_W'({1'b0, r_pm}));

    function automatic logic signed [sfo_pkg::OP_W-1:0] pick(input sfo_pkg::t_src s,
            input logic [30:0] rs, input logic [30:0] ls, input logic [30:0] il,
            input logic [30:0] ga, input logic [30:0] gb, input logic [31:0] ts,
            input logic signed [sfo_pkg::OP_W-1:0] cs,
            input logic signed [sfo_pkg::OP_W-1:0] sn,
            input logic signed [31:0] fa, input logic signed [31:0] fb,
            input logic signed [31:0] ia, input logic signed [31:0] ib,
            input logic signed [31:0] pa, input logic signed [31:0] pb,
            input logic signed [31:0] d, input logic signed [31:0] q,
            input logic signed [31:0] dm, input logic signed [31:0] ea,
            input logic signed [31:0] eb, input logic signed [31:0] ta,
            input logic signed [31:0] tb);
        logic signed [sfo_pkg::OP_W-1:0] v;
        begin
            unique case (s)
                sfo_pkg::SRC_RS:   v = {2'b00, rs};
                sfo_pkg::SRC_LS:   v = {2'b00, ls};
                sfo_pkg::SRC_IL:   v = {2'b00, il};
                sfo_pkg::SRC_GA:   v = {2'b00, ga};
                sfo_pkg::SRC_GB:   v = {2'b00, gb};
                sfo_pkg::SRC_TS:   v = {1'b0, ts};
                sfo_pkg::SRC_COS:  v = cs;
                sfo_pkg::SRC_SIN:  v = sn;
                sfo_pkg::SRC_FA:   v = sfo_pkg::OP_W'(fa);
                sfo_pkg::SRC_FB:   v = sfo_pkg::OP_W'(fb);
                sfo_pkg::SRC_IA:   v = sfo_pkg::OP_W'(ia);
                sfo_pkg::SRC_IB:   v = sfo_pkg::OP_W'(ib);
                sfo_pkg::SRC_PCA:  v = sfo_pkg::OP_W'(pa);
                sfo_pkg::SRC_PCB:  v = sfo_pkg::OP_W'(pb);
                sfo_pkg::SRC_D:    v = sfo_pkg::OP_W'(d);
                sfo_pkg::SRC_Q:    v = sfo_pkg::OP_W'(q);
                sfo_pkg::SRC_DMPM: v = sfo_pkg::OP_W'(dm);
                sfo_pkg::SRC_EA:   v = sfo_pkg::OP_W'(ea);
                sfo_pkg::SRC_EB:   v = sfo_pkg::OP_W'(eb);
                sfo_pkg::SRC_TA:   v = sfo_pkg::OP_W'(ta);
                sfo_pkg::SRC_TB:   v = sfo_pkg::OP_W'(tb);
                default:           v = '0;
            endcase
            return v;
        end
    endfunction

    assign w_a = pick(w_uop.a, r_rs, r_ls, r_il, r_ga, r_gb, r_ts, r_cos, r_sin, r_fa, r_fb,
                      r_ia, r_ib, r_pca, r_pcb, r_d, r_q, w_dmpm, r_ea, r_eb, r_ta, r_tb);
    assign w_b = pick(w_uop.b, r_rs, r_ls, r_il, r_ga, r_gb, r_ts, r_cos, r_sin, r_fa, r_fb,
                      r_ia, r_ib, r_pca, r_pcb, r_d, r_q, w_dmpm, r_ea, r_eb, r_ta, r_tb);

    always_comb begin
        unique case (w_uop.k)
            sfo_pkg::K_VA: w_k = r_va;
            sfo_pkg::K_VB: w_k = r_vb;
            sfo_pkg::K_IA: w_k = r_ia;
            sfo_pkg::K_IB: w_k = r_ib;
            sfo_pkg::K_FA: w_k = r_fa;
            sfo_pkg::K_FB: w_k = r_fb;
            sfo_pkg::K_PM: w_k = {1'b0, r_pm};
            sfo_pkg::K_XA: w_k = r_xa;
            sfo_pkg::K_XB: w_k = r_xb;
            default:       w_k = '0;
        endcase
    end

    sfo_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_mac),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_k    (w_k),
        .o_res  (w_res)
    );

    sfo_cordic u_cordic (
        .i_clk  (i_clk),
        .i_ctrl (w_cor),
        .i_x    (w_lx),
        .i_y    (w_ly),
        .i_z    (w_lz),
        .o_x    (w_cx),
        .o_y    (w_cy),
        .o_z    (w_cz),
        .o_last (w_clast)
    );

    // ---- CORDIC load values
    assign w_turn = 32'(r_ang) << (32 - AB);

    always_comb begin
        if (r_state == sfo_pkg::ST_ALOAD) begin
            if (r_oa < 0) begin
                w_lx = -sfo_pkg::CORDIC_W'(r_oa);
                w_ly = -sfo_pkg::CORDIC_W'(r_ob);
                w_lz = sfo_pkg::Z_W'(33'h080000000);
            end else begin
                w_lx = sfo_pkg::CORDIC_W'(r_oa);
                w_ly = sfo_pkg::CORDIC_W'(r_ob);
                w_lz = '0;
            end
        end else begin
            // fold the left half-plane onto the right and negate at the end
            w_lx = sfo_pkg::CORDIC_W'({1'b0, sfo_pkg::CORDIC_K});
            w_ly = '0;
            w_lz = sfo_pkg::Z_W'($signed({w_turn[30], w_turn[30:0]}));
        end
    end

    // ---- angle rounding
    assign w_ang32 = r_zero ? 32'd0 : (w_cz[31:0] + (32'd1 << (31 - AB)));
    assign w_ang   = w_ang32[31 -: AB];
    assign w_emit  = (r_state == sfo_pkg::ST_DONE) && (!r_out_valid || o_out.ready);

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        w_mac   = '{1'b0, 1'b0, w_uop.first, w_uop.neg, w_uop.sh, w_uop.post};
        w_cor   = '{1'b0, 1'b0, 1'b0};
        unique case (r_state)
            sfo_pkg::ST_IDLE: begin
                if (w_accept) begin
                    w_cor.load = 1'b1;
                    n_state = sfo_pkg::ST_SINCOS;
                end
            end
            sfo_pkg::ST_SINCOS: begin
                w_cor.run = 1'b1;
                if (w_clast) begin
                    n_state = sfo_pkg::ST_SCSTORE;
                end
            end
            sfo_pkg::ST_SCSTORE: begin
                n_upc   = '0;
                n_state = sfo_pkg::ST_MUL;
            end
            sfo_pkg::ST_MUL: begin
                w_mac.mul_en = 1'b1;
                n_state = sfo_pkg::ST_ACC;
            end
            sfo_pkg::ST_ACC: begin
                w_mac.acc_en = 1'b1;
                if (w_uop.last) begin
                    n_state = sfo_pkg::ST_WB;
                end else begin
                    n_upc   = r_upc + 1'b1;
                    n_state = sfo_pkg::ST_MUL;
                end
            end
            sfo_pkg::ST_WB: begin
                if (r_upc == sfo_pkg::UOP_W'(sfo_pkg::UOP_N - 1)) begin
                    n_state = sfo_pkg::ST_DIFF;
                end else begin
                    n_upc   = r_upc + 1'b1;
                    n_state = sfo_pkg::ST_MUL;
                end
            end
            sfo_pkg::ST_DIFF: begin
                n_state = sfo_pkg::ST_ALOAD;
            end
            sfo_pkg::ST_ALOAD: begin
                w_cor.load = 1'b1;
                n_state = sfo_pkg::ST_ATAN;
            end
            sfo_pkg::ST_ATAN: begin
                w_cor.run    = 1'b1;
                w_cor.vector = 1'b1;
                if (w_clast) begin
                    n_state = sfo_pkg::ST_DONE;
                end
            end
            sfo_pkg::ST_DONE: begin
                w_cor.vector = 1'b1;
                if (w_emit) begin
                    n_state = sfo_pkg::ST_IDLE;
                end
            end
            default: n_state = sfo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfo_pkg::ST_IDLE;
            r_upc   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

    // ---- observer state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa  <= '0;
            r_fb  <= '0;
            r_pca <= '0;
            r_pcb <= '0;
            r_ang <= '0;
        end else begin
            if (r_state == sfo_pkg::ST_WB && w_uop.dst == sfo_pkg::DST_FA) begin
                r_fa <= w_res;
            end
            if (r_state == sfo_pkg::ST_WB && w_uop.dst == sfo_pkg::DST_FB) begin
                r_fb <= w_res;
            end
            if (w_emit) begin
                r_ang <= w_ang;
                r_pca <= r_ia;
                r_pcb <= r_ib;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_va  <= i_in.data.volt_alpha;
            r_vb  <= i_in.data.volt_beta;
            r_ia  <= i_in.data.curr_alpha;
            r_ib  <= i_in.data.curr_beta;
            r_neg <= w_turn[31] ^ w_turn[30];
        end
        if (r_state == sfo_pkg::ST_SCSTORE) begin
            r_cos <= r_neg ? -sfo_pkg::OP_W'(w_cx) : sfo_pkg::OP_W'(w_cx);
            r_sin <= r_neg ? -sfo_pkg::OP_W'(w_cy) : sfo_pkg::OP_W'(w_cy);
        end
        if (r_state == sfo_pkg::ST_WB) begin
            unique case (w_uop.dst)
                sfo_pkg::DST_XA: r_xa <= w_res;
                sfo_pkg::DST_XB: r_xb <= w_res;
                sfo_pkg::DST_LA: r_la <= w_res;
                sfo_pkg::DST_LB: r_lb <= w_res;
                sfo_pkg::DST_D:  r_d  <= w_res;
                sfo_pkg::DST_Q:  r_q  <= w_res;
                sfo_pkg::DST_EA: r_ea <= w_res;
                sfo_pkg::DST_EB: r_eb <= w_res;
                sfo_pkg::DST_TA: r_ta <= w_res;
                sfo_pkg::DST_TB: r_tb <= w_res;
                default: ;
            endcase
        end
        if (r_state == sfo_pkg::ST_DIFF) begin
            r_oa <= sfo_pkg::sat(sfo_pkg::SUM_W'(r_fa) - sfo_pkg::SUM_W'(r_la));
            r_ob <= sfo_pkg::sat(sfo_pkg::SUM_W'(r_fb) - sfo_pkg::SUM_W'(r_lb));
        end
        if (r_state == sfo_pkg::ST_ALOAD) begin
            r_zero <= (r_oa == 32'sd0) && (r_ob == 32'sd0);
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.rotor_angle    <= 16'((48'(w_ang) << 16) >> AB);
            r_out.flux_alpha_est <= r_oa;
            r_out.flux_beta_est  <= r_ob;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[rtl/sfo_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfo_mac
// Shared multiply-accumulate with rounding shift, saturation and offset add.
// ----------------------------------------------------------------------------
module sfo_mac (
    input  logic                             i_clk,
    input  sfo_pkg::t_mac_ctrl               i_ctrl,
    input  logic signed [sfo_pkg::OP_W-1:0]  i_a,
    input  logic signed [sfo_pkg::OP_W-1:0]  i_b,
    input  logic signed [31:0]               i_k,
    output logic signed [31:0]               o_res
);

    logic signed [sfo_pkg::PROD_W-1:0] r_prod;
    logic signed [sfo_pkg::ACC_W-1:0]  r_acc;
    logic signed [sfo_pkg::ACC_W-1:0]  w_p;
    logic signed [sfo_pkg::ACC_W-1:0]  w_r;
    logic signed [31:0]                w_y;
    logic signed [sfo_pkg::SUM_W-1:0]  w_k;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctrl.acc_en) begin
            if (i_ctrl.first) begin
                r_acc <= i_ctrl.neg ? -w_p : w_p;
            end else begin
                r_acc <= i_ctrl.neg ? r_acc - w_p : r_acc + w_p;
            end
        end
    end

    assign w_p = sfo_pkg::ACC_W'(r_prod);
    assign w_k = sfo_pkg::SUM_W'(i_k);

    // round half up, then arithmetic shift
    always_comb begin
        unique case (i_ctrl.sh)
            sfo_pkg::SH_16: w_r = (r_acc + sfo_pkg::ACC_W'(1 << 15)) >>> 16;
            sfo_pkg::SH_20: w_r = (r_acc + sfo_pkg::ACC_W'(1 << 19)) >>> 20;
            sfo_pkg::SH_28: w_r = (r_acc + sfo_pkg::ACC_W'(1 << 27)) >>> 28;
            sfo_pkg::SH_30: w_r = (r_acc + sfo_pkg::ACC_W'(1 << 29)) >>> 30;
            default:        w_r = r_acc;
        endcase
    end

    assign w_y = sfo_pkg::sat(sfo_pkg::SUM_W'(w_r));

    always_comb begin
        unique case (i_ctrl.post)
            sfo_pkg::POST_SAT:  o_res = w_y;
            sfo_pkg::POST_KSUB: o_res = sfo_pkg::sat(w_k - sfo_pkg::SUM_W'(w_y));
            sfo_pkg::POST_SUBK: o_res = sfo_pkg::sat(sfo_pkg::SUM_W'(w_y) - w_k);
            sfo_pkg::POST_ADDK: o_res = sfo_pkg::sat(w_k + sfo_pkg::SUM_W'(w_r));
            default:            o_res = w_y;
        endcase
    end

endmodule

[rtl/sfo_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfo_cordic
// Iterative CORDIC, one micro-rotation per cycle while run is set, rotation or vectoring.
// ----------------------------------------------------------------------------
module sfo_cordic (
    input  logic                                  i_clk,
    input  sfo_pkg::t_cor_ctrl                    i_ctrl,
    input  logic signed [sfo_pkg::CORDIC_W-1:0]   i_x,
    input  logic signed [sfo_pkg::CORDIC_W-1:0]   i_y,
    input  logic signed [sfo_pkg::Z_W-1:0]        i_z,
    output logic signed [sfo_pkg::CORDIC_W-1:0]   o_x,
    output logic signed [sfo_pkg::CORDIC_W-1:0]   o_y,
    output logic signed [sfo_pkg::Z_W-1:0]        o_z,
    output logic                                  o_last
);

    logic signed [sfo_pkg::CORDIC_W-1:0] r_x, r_y;
    logic signed [sfo_pkg::Z_W-1:0]      r_z;
    logic [sfo_pkg::STEP_W-1:0]          r_i;
    logic signed [sfo_pkg::CORDIC_W-1:0] w_xs, w_ys;
    logic signed [sfo_pkg::Z_W-1:0]      w_a;
    logic                                w_cw;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_a  = sfo_pkg::Z_W'(sfo_pkg::atan_turn(5'(r_i)));
    // rotate back toward the axis: y nonnegative when vectoring, z negative when rotating
    assign w_cw = i_ctrl.vector ? !r_y[sfo_pkg::CORDIC_W-1] : r_z[sfo_pkg::Z_W-1];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
            r_i <= '0;
        end else if (i_ctrl.run) begin
            if (w_cw) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_a;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_a;
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_last = (r_i == sfo_pkg::STEP_W'(sfo_pkg::CORDIC_STEPS - 1));

endmodule

[rtl/sfo_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfo_chk
// Port-level checks of the flux observer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sensorless_flux_observer_top_macros.svh"

module sfo_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_angle
);

    // one word in flight: no second word right behind the first
    `SFO_ASSERT(a_busy_after_accept, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready after accept")
    // a result never appears the cycle after a word enters
    `SFO_ASSERT(a_no_early_result, (i_in_valid && i_in_ready) |=> !$rose(i_out_valid), "early result")
    `SFO_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_angle)), "stalled result dropped")
    `SFO_ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> (!i_out_valid && i_in_ready), "reset state wrong")

endmodule

bind sensorless_flux_observer_top sfo_chk u_sfo_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_angle (o_out.data.rotor_angle)
);
